// ----- sv/cstk_pkg.sv -----
package cstk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ACTION_W  = 2;
  localparam int VALUE_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_POP    = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_SHIFT,
    S_TOP,
    S_TOPW,
    S_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_PUSH,
    DP_POP,
    DP_SRCH_START,
    DP_SRCH_NEXT,
    DP_SHIFT_RD,
    DP_SHIFT_STEP,
    DP_SHIFT_LAST,
    DP_TOP_RD,
    DP_TOP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    st_we;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    empty;
    logic    full;
    logic    match;
    logic    idx_zero;
    logic    idx_top;
    logic    shift_last;
  } dp_sts_t;

endpackage

// ----- sv/char_stack_with_remove_by_value.sv -----
// Byte stack of DEPTH entries with push, pop and remove of the newest entry equal to a
// given byte. A word is taken when start is high while busy is low, and its one result
// word shows on the out_ ports for exactly one cycle with out_valid; the receiver cannot
// stall it, so it must take every result as it comes. The entries live in a memory
// with one write and one read port whose read data is registered; each search step
// reads one entry and each shift step moves one entry, one entry per cycle. A push,
// a rejected operation or an ignored action ends without a memory read. A pop reads
// the new top back from memory, unless it empties the stack. A remove searches down
// from the top, closes the gap above its match by shifting those entries down, then
// reads the new top; a miss ends at the bottom. No word is taken until the result is out.
module char_stack_with_remove_by_value #(
  parameter int DEPTH = cstk_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [cstk_pkg::ACTION_W-1:0]  in_action,
  input  logic [cstk_pkg::VALUE_W-1:0]   in_value,
  output logic                           out_valid,
  output logic [cstk_pkg::STATUS_W-1:0]  out_status,
  output logic [cstk_pkg::COUNT_W-1:0]   out_count,
  output logic [cstk_pkg::VALUE_W-1:0]   out_top_value
);
  import cstk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_top_value (out_top_value)
  );

endmodule

// ----- sv/cstk_dp.sv -----
module cstk_dp #(
  parameter int DEPTH = cstk_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cstk_pkg::ACTION_W-1:0]  in_action,
  input  logic [cstk_pkg::VALUE_W-1:0]   in_value,
  input  cstk_pkg::dp_cmd_t              cmd,
  output cstk_pkg::dp_sts_t              sts,
  output logic [cstk_pkg::STATUS_W-1:0]  out_status,
  output logic [cstk_pkg::COUNT_W-1:0]   out_count,
  output logic [cstk_pkg::VALUE_W-1:0]   out_top_value
);
  import cstk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] mem [DEPTH];

  action_t            act_r;
  logic [VALUE_W-1:0] val_r;
  status_t            st_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [VALUE_W-1:0] top_r, top_nxt;
  logic [VALUE_W-1:0] rd_data_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data_r;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    top_nxt = top_r;
    unique case (cmd.op)
      DP_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = val_r;
        cnt_nxt = cnt_r + CW'(1);
        top_nxt = val_r;
      end
      DP_POP: begin
        cnt_nxt = cnt_r - CW'(1);
      end
      DP_SRCH_START: begin
        idx_nxt = AW'(cnt_r - CW'(1));
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_r - CW'(1));
      end
      DP_SRCH_NEXT: begin
        idx_nxt = idx_r - AW'(1);
        rd_en   = 1'b1;
        rd_addr = idx_r - AW'(1);
      end
      DP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r + AW'(1);
      end
      DP_SHIFT_STEP: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + AW'(1);
        rd_en   = 1'b1;
        rd_addr = idx_r + AW'(2);
      end
      DP_SHIFT_LAST: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r - CW'(1);
      end
      DP_TOP_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_r - CW'(1));
      end
      DP_TOP_LOAD: begin
        top_nxt = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    top_r <= top_nxt;
    if (cmd.op == DP_LATCH) begin
      act_r <= action_t'(in_action);
      val_r <= in_value;
      st_r  <= ST_OK;
    end else if (cmd.st_we) begin
      st_r <= cmd.st;
    end
  end

  assign sts.act        = act_r;
  assign sts.empty      = (cnt_r == '0);
  assign sts.full       = (cnt_r == CW'(DEPTH));
  assign sts.match      = (rd_data_r == val_r);
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.idx_top    = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign sts.shift_last = ((CW'(idx_r) + CW'(2)) == cnt_r);

  assign out_status    = st_r;
  assign out_count     = COUNT_W'(cnt_r);
  assign out_top_value = (cnt_r == '0) ? '0 : top_r;

endmodule

// ----- sv/cstk_ctrl.sv -----
module cstk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cstk_pkg::dp_sts_t sts,
  output cstk_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import cstk_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.act)
          ACT_PUSH:   state_nxt = S_DONE;
          ACT_POP:    state_nxt = sts.empty ? S_DONE : S_TOP;
          ACT_REMOVE: state_nxt = sts.empty ? S_DONE : S_SRCH;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SRCH: begin
        if (sts.match) begin
          state_nxt = sts.idx_top ? S_TOP : S_SHIFT;
        end else if (sts.idx_zero) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts.shift_last) begin
          state_nxt = S_TOP;
        end
      end
      S_TOP:   state_nxt = sts.empty ? S_DONE : S_TOPW;
      S_TOPW:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = DP_NOP;
    cmd.st_we = 1'b0;
    cmd.st    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_LATCH;
        end
      end
      S_EXEC: begin
        unique case (sts.act)
          ACT_PUSH: begin
            if (sts.full) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_FULL;
            end else begin
              cmd.op = DP_PUSH;
            end
          end
          ACT_POP: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_EMPTY;
            end else begin
              cmd.op = DP_POP;
            end
          end
          ACT_REMOVE: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_EMPTY;
            end else begin
              cmd.op = DP_SRCH_START;
            end
          end
          default: begin
          end
        endcase
      end
      S_SRCH: begin
        if (sts.match) begin
          cmd.op = sts.idx_top ? DP_POP : DP_SHIFT_RD;
        end else if (sts.idx_zero) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_NOT_FOUND;
        end else begin
          cmd.op = DP_SRCH_NEXT;
        end
      end
      S_SHIFT: cmd.op = sts.shift_last ? DP_SHIFT_LAST : DP_SHIFT_STEP;
      S_TOP: begin
        if (!sts.empty) begin
          cmd.op = DP_TOP_RD;
        end
      end
      S_TOPW:  cmd.op = DP_TOP_LOAD;
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ----- sv/cstk_chk.sv -----
module cstk_chk #(
  parameter int DEPTH = cstk_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [cstk_pkg::STATUS_W-1:0] out_status,
  input logic [cstk_pkg::COUNT_W-1:0]  out_count,
  input logic [cstk_pkg::VALUE_W-1:0]  out_top_value
);
  import cstk_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not make the block busy");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0 && DEPTH < 32) |-> (out_top_value == '0))
    else $error("empty stack reported a nonzero top");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == FULL_CNT))
    else $error("full status with count below depth");

endmodule

bind char_stack_with_remove_by_value cstk_chk #(
  .DEPTH (DEPTH)
) u_cstk_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_count     (out_count),
  .out_top_value (out_top_value)
);
